// ----- hdl/rcav_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcav_pkg
// Shared types and constants of the record chain archive validator.
// ----------------------------------------------------------------------------
package rcav_pkg;

    localparam int HDR_LEN = 27;
    localparam int TRAILER_LEN = 5;
    localparam logic [7:0] LEN_BYTE = 8'h0C;
    localparam logic [7:0] MARKER_BYTE = 8'h24;
    localparam logic [7:0] BLANK_BYTE = 8'h20;
    localparam int MIN_TOTAL = 32;

    localparam logic [1:0] REG_TOTAL_SIZE = 2'd0;
    localparam logic [1:0] REG_MAX_MEMBERS = 2'd1;
    localparam logic [1:0] REG_MAX_MEMBER_SIZE = 2'd2;

    typedef struct packed {
        logic        result_kind;
        logic [16:0] member_index;
        logic [31:0] header_offset;
        logic [31:0] data_offset;
        logic [30:0] packed_size;
        logic [30:0] unpacked_size;
        logic [31:0] dos_stamp;
        logic        pack_method;
        logic        archive_valid;
        logic [31:0] trailer_offset;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

endpackage
`default_nettype wire

// ----- hdl/rcav_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcav_if
// Valid/ready channel interfaces for input bytes, results and configuration.
// ----------------------------------------------------------------------------
interface rcav_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rcav_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [16:0] member_index;
    logic [31:0] header_offset;
    logic [31:0] data_offset;
    logic [30:0] packed_size;
    logic [30:0] unpacked_size;
    logic [31:0] dos_stamp;
    logic        pack_method;
    logic        archive_valid;
    logic [31:0] trailer_offset;
    logic        last_result;
    modport source (output valid, output result_kind, output member_index,
        output header_offset, output data_offset, output packed_size,
        output unpacked_size, output dos_stamp, output pack_method,
        output archive_valid, output trailer_offset, output last_result,
        input ready);
    modport sink (input valid, input result_kind, input member_index,
        input header_offset, input data_offset, input packed_size,
        input unpacked_size, input dos_stamp, input pack_method,
        input archive_valid, input trailer_offset, input last_result,
        output ready);
endinterface

interface rcav_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/rcav_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcav_parser
// Front part: parses one byte per stepped cycle and pushes up to two results.
// ----------------------------------------------------------------------------
module rcav_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire rcav_pkg::item_t      item,
    input  wire logic [31:0]          total_size,
    input  wire logic [16:0]          max_members,
    input  wire logic [30:0]          max_member_size,
    output rcav_pkg::result_t         res0,
    output rcav_pkg::result_t         res1,
    output logic [1:0]                res_count
);
    localparam int OB = OFFSET_BITS;
    localparam int WB = ((OB > 32) ? OB : 32) + 2;
    localparam logic [OB-1:0] POS_MAX = {OB{1'b1}};

    typedef enum logic [2:0] {
        PH_HEADER, PH_PRELUDE, PH_PAYLOAD, PH_DONE, PH_FATAL
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [OB-1:0] pos_reg, pos_next, rstart_reg, rstart_next, cend_reg, cend_next;
    logic [4:0] hcnt_reg, hcnt_next;
    logic [31:0] pk_reg, pk_next, up_reg, up_next, st_reg, st_next;
    logic [7:0] meth_reg, meth_next;
    logic bad_reg, bad_next, nb_reg, nb_next;
    logic [31:0] left_reg, left_next;
    logic [16:0] mcount_reg, mcount_next;

    logic [WB-1:0] tot_w, p_w;
    logic [7:0] b;
    logic [1:0] bsel;
    logic hbad;
    logic emit;
    rcav_pkg::result_t desc, verd;
    logic [OB-1:0] ce;
    logic ok;

    assign tot_w = WB'(total_size);
    assign p_w = WB'(pos_reg);
    assign b = item.data_byte;
    assign bsel = hcnt_reg[1:0] - 2'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        rstart_next = rstart_reg;
        cend_next = cend_reg;
        hcnt_next = hcnt_reg;
        pk_next = pk_reg;
        up_next = up_reg;
        st_next = st_reg;
        meth_next = meth_reg;
        bad_next = bad_reg;
        nb_next = nb_reg;
        left_next = left_reg;
        mcount_next = mcount_reg;
        emit = 1'b0;
        hbad = 1'b0;
        desc = '0;
        verd = '0;
        ce = '0;
        ok = 1'b0;
        res0 = '0;
        res1 = '0;
        res_count = 2'd0;
        if (step)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hcnt_reg == 5'd0 && total_size < 32'(rcav_pkg::MIN_TOTAL))
                    begin
                        rstart_next = pos_reg;
                        phase_next = PH_FATAL;
                    end
                    else if (hcnt_reg == 5'd0
                             && p_w + WB'(rcav_pkg::HDR_LEN) > tot_w)
                    begin
                        rstart_next = pos_reg;
                        cend_next = pos_reg;
                        phase_next = PH_DONE;
                    end
                    else if (hcnt_reg == 5'd0 && mcount_reg >= max_members)
                    begin
                        rstart_next = pos_reg;
                        phase_next = PH_FATAL;
                    end
                    else
                    begin
                        if (hcnt_reg == 5'd0)
                        begin
                            rstart_next = pos_reg;
                            if (b != rcav_pkg::LEN_BYTE)
                                bad_next = 1'b1;
                        end
                        else if (hcnt_reg <= 5'd12)
                        begin
                            if (b < rcav_pkg::BLANK_BYTE)
                                bad_next = 1'b1;
                            if (b != rcav_pkg::BLANK_BYTE)
                                nb_next = 1'b1;
                        end
                        else if (hcnt_reg <= 5'd16)
                            pk_next[{bsel, 3'b000} +: 8] = b;
                        else if (hcnt_reg <= 5'd20)
                            up_next[{bsel, 3'b000} +: 8] = b;
                        else if (hcnt_reg <= 5'd24)
                            st_next[{bsel, 3'b000} +: 8] = b;
                        else if (hcnt_reg == 5'd25)
                            meth_next = b;
                        if (hcnt_reg >= 5'd26)
                        begin
                            hbad = bad_reg || !nb_reg || b != rcav_pkg::MARKER_BYTE
                                || pk_reg[31] || up_reg[31]
                                || pk_reg[30:0] > max_member_size
                                || up_reg[30:0] > max_member_size
                                || meth_reg > 8'd1
                                || (meth_reg == 8'd0 && pk_reg != up_reg)
                                || p_w + WB'(1) + WB'(pk_reg) > tot_w
                                || (meth_reg == 8'd1 && pk_reg < 32'd3);
                            left_next = pk_reg;
                            hcnt_next = 5'd0;
                            if (hbad)
                            begin
                                phase_next = PH_DONE;
                                cend_next = rstart_reg;
                            end
                            else if (meth_reg == 8'd1)
                                phase_next = PH_PRELUDE;
                            else
                            begin
                                emit = 1'b1;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        else
                            hcnt_next = hcnt_reg + 5'd1;
                    end
                end
                PH_PRELUDE:
                begin
                    if (hcnt_reg == 5'd0)
                    begin
                        if (b > 8'd1)
                        begin
                            phase_next = PH_DONE;
                            cend_next = rstart_reg;
                        end
                        else
                            hcnt_next = 5'd1;
                    end
                    else if (b < 8'd4 || b > 8'd6)
                    begin
                        phase_next = PH_DONE;
                        cend_next = rstart_reg;
                    end
                    else
                    begin
                        emit = 1'b1;
                        left_next = (left_reg >= 32'd2) ? left_reg - 32'd2 : 32'd0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (left_reg != 32'd0)
                        left_next = left_reg - 32'd1;
                end
                default:
                begin
                end
            endcase
            if (emit)
            begin
                desc.member_index = mcount_reg;
                desc.header_offset = 32'(rstart_next);
                desc.data_offset = 32'(rstart_next) + 32'(rcav_pkg::HDR_LEN);
                desc.packed_size = pk_reg[30:0];
                desc.unpacked_size = up_reg[30:0];
                desc.dos_stamp = st_reg;
                desc.pack_method = meth_reg[0];
                mcount_next = mcount_reg + 17'd1;
            end
            if (phase_next == PH_PAYLOAD && left_next == 32'd0)
            begin
                phase_next = PH_HEADER;
                rstart_next = OB'(p_w + WB'(1));
                hcnt_next = 5'd0;
                pk_next = '0;
                up_next = '0;
                st_next = '0;
                meth_next = '0;
                bad_next = 1'b0;
                nb_next = 1'b0;
            end
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + OB'(1);
            if (item.last_byte)
            begin
                ce = (phase_next == PH_DONE) ? cend_next : rstart_next;
                ok = phase_next != PH_FATAL && total_size >= 32'(rcav_pkg::MIN_TOTAL)
                    && mcount_next != 17'd0 && p_w + WB'(1) == tot_w
                    && (WB'(ce) == tot_w || WB'(ce) + WB'(rcav_pkg::TRAILER_LEN) == tot_w);
                verd.result_kind = 1'b1;
                verd.archive_valid = ok;
                verd.trailer_offset = 32'(ce);
                verd.last_result = 1'b1;
                phase_next = PH_HEADER;
                pos_next = '0;
                rstart_next = '0;
                cend_next = '0;
                hcnt_next = '0;
                pk_next = '0;
                up_next = '0;
                st_next = '0;
                meth_next = '0;
                bad_next = 1'b0;
                nb_next = 1'b0;
                left_next = '0;
                mcount_next = '0;
            end
            else
                desc.last_result = 1'b1;
            if (emit)
            begin
                res0 = desc;
                res1 = verd;
                res_count = item.last_byte ? 2'd2 : 2'd1;
            end
            else if (item.last_byte)
            begin
                res0 = verd;
                res_count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg <= '0;
            rstart_reg <= '0;
            cend_reg <= '0;
            hcnt_reg <= '0;
            pk_reg <= '0;
            up_reg <= '0;
            st_reg <= '0;
            meth_reg <= '0;
            bad_reg <= 1'b0;
            nb_reg <= 1'b0;
            left_reg <= '0;
            mcount_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            rstart_reg <= rstart_next;
            cend_reg <= cend_next;
            hcnt_reg <= hcnt_next;
            pk_reg <= pk_next;
            up_reg <= up_next;
            st_reg <= st_next;
            meth_reg <= meth_next;
            bad_reg <= bad_next;
            nb_reg <= nb_next;
            left_reg <= left_next;
            mcount_reg <= mcount_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/rcav_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcav_queue
// Result queue between parser and output; takes up to two results per cycle.
// ----------------------------------------------------------------------------
module rcav_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rcav_pkg::result_t wr0,
    input  wire rcav_pkg::result_t wr1,
    input  wire logic [1:0]        wr_count,
    output logic                   space_ok,
    output logic                   rd_valid,
    output rcav_pkg::result_t      rd_data,
    input  wire logic              rd_ready
);
    rcav_pkg::result_t mem [4];
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic rd;

    assign rd = rd_valid && rd_ready;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data = mem[rp_reg];
    assign space_ok = cnt_reg <= 3'd2;
    assign wp_next = wp_reg + wr_count;
    assign rp_next = rp_reg + {1'b0, rd};
    assign cnt_next = cnt_reg + {1'b0, wr_count} - {2'b0, rd};

    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
            mem[wp_reg] <= wr0;
        if (wr_count == 2'd2)
            mem[wp_reg + 2'd1] <= wr1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/record_chain_archive_validator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// record_chain_archive_validator_top
// Streaming validator for chained record archives with 27-byte headers.
// ----------------------------------------------------------------------------
// One archive byte is taken per clock cycle; the parser classifies each byte
// combinationally and writes up to two results into a four-entry queue,
// which drains one result per cycle while the output channel is ready. Input
// is held off only when the queue has fewer than two free entries.
module record_chain_archive_validator_top #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rcav_in_if.sink    in_ch,
    rcav_out_if.source out_ch,
    rcav_cfg_if.sink   cfg
);
    logic [31:0] total_size_reg;
    logic [16:0] max_members_reg;
    logic [30:0] max_member_size_reg;
    rcav_pkg::item_t item;
    rcav_pkg::result_t r0, r1, rq;
    logic [1:0] rcount;
    logic space_ok, step;

    assign cfg.ready = 1'b1;
    assign in_ch.ready = space_ok;
    assign step = in_ch.valid && space_ok;
    assign item.data_byte = in_ch.data_byte;
    assign item.last_byte = in_ch.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_size_reg <= '0;
            max_members_reg <= 17'd100000;
            max_member_size_reg <= 31'd268435456;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rcav_pkg::REG_TOTAL_SIZE: total_size_reg <= cfg.data;
                rcav_pkg::REG_MAX_MEMBERS: max_members_reg <= cfg.data[16:0];
                rcav_pkg::REG_MAX_MEMBER_SIZE: max_member_size_reg <= cfg.data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    rcav_parser #(.OFFSET_BITS(OFFSET_BITS)) u_parser (
        .clk(clk), .rst_n(rst_n), .step(step), .item(item),
        .total_size(total_size_reg), .max_members(max_members_reg),
        .max_member_size(max_member_size_reg),
        .res0(r0), .res1(r1), .res_count(rcount)
    );

    rcav_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr0(r0), .wr1(r1), .wr_count(rcount),
        .space_ok(space_ok), .rd_valid(out_ch.valid), .rd_data(rq),
        .rd_ready(out_ch.ready)
    );

    assign out_ch.result_kind = rq.result_kind;
    assign out_ch.member_index = rq.member_index;
    assign out_ch.header_offset = rq.header_offset;
    assign out_ch.data_offset = rq.data_offset;
    assign out_ch.packed_size = rq.packed_size;
    assign out_ch.unpacked_size = rq.unpacked_size;
    assign out_ch.dos_stamp = rq.dos_stamp;
    assign out_ch.pack_method = rq.pack_method;
    assign out_ch.archive_valid = rq.archive_valid;
    assign out_ch.trailer_offset = rq.trailer_offset;
    assign out_ch.last_result = rq.last_result;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !space_ok |-> rcount == 2'd0)
        else $error("result pushed without queue space");
    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_ch.last_byte |-> rcount != 2'd0)
        else $error("last byte produced no verdict");
    a_verdict_only_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.result_kind |-> out_ch.last_result)
        else $error("verdict not marked last");
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the record chain archive validator.
// ----------------------------------------------------------------------------
// Archives are built from headers, payloads and trailers, some of them broken
// on purpose, and streamed one byte per transfer. A model of the parser
// predicts the descriptors and the verdict of every archive, and each result
// transfer is compared with the oldest prediction. Both channels idle at
// random, and one pass holds the result channel off long enough to stall
// the byte input.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT_CYCLES = 600000;
    localparam logic [7:0] M_STORED = 8'd0;
    localparam logic [7:0] M_IMPLODE = 8'd1;
    localparam logic KIND_MEMBER = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;
    localparam logic [63:0] POS_MAX = 64'hFFFF_FFFF;

    typedef enum logic [2:0] {P_HDR, P_PRE, P_PAY, P_DONE, P_FATAL} phase_t;
    typedef enum int {F_NONE, F_LEN, F_BLANK, F_CTRL, F_MARK, F_METH,
                      F_PRE0, F_PRE1} fault_t;

    logic clk;
    logic rst_n;
    rcav_in_if  in_ch();
    rcav_out_if out_ch();
    rcav_cfg_if cfg();

    record_chain_archive_validator_top u_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
    );

    // Register copies.
    logic [63:0] reg_total;
    logic [63:0] reg_max_members;
    logic [63:0] reg_max_size;

    // Parser state of the prediction.
    phase_t      ph;
    logic [63:0] pos, rec_start, chain_end, pay_left, mcount;
    int          hdr_cnt;
    logic [31:0] pk_acc, up_acc, stamp_acc;
    logic [7:0]  meth;
    logic        hbad, nonblank;

    rcav_pkg::result_t expected_results[$];
    logic [7:0]  arc_bytes[$];

    int errors = 0;
    int bytes_sent = 0;
    int members_seen = 0;
    int verdicts_seen = 0;
    int valid_verdicts = 0;
    int archives = 0;
    int hold_req = 0;
    bit quiet = 0;
    longint cycles = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic clear_stream();
        ph = P_HDR; pos = 0; rec_start = 0; hdr_cnt = 0;
        pk_acc = 0; up_acc = 0; stamp_acc = 0; meth = 0;
        hbad = 0; nonblank = 0; pay_left = 0; mcount = 0; chain_end = 0;
    endtask

    task automatic open_record(input logic [63:0] start);
        ph = P_HDR; rec_start = start & POS_MAX; hdr_cnt = 0;
        pk_acc = 0; up_acc = 0; stamp_acc = 0; meth = 0;
        hbad = 0; nonblank = 0;
    endtask

    task automatic close_chain();
        ph = P_DONE;
        chain_end = rec_start;
    endtask

    task automatic push_member();
        rcav_pkg::result_t r;
        r = '0;
        r.result_kind = KIND_MEMBER;
        r.member_index = mcount[16:0];
        r.header_offset = rec_start[31:0];
        r.data_offset = rec_start[31:0] + 32'(rcav_pkg::HDR_LEN);
        r.packed_size = pk_acc[30:0];
        r.unpacked_size = up_acc[30:0];
        r.dos_stamp = stamp_acc;
        r.pack_method = meth[0];
        expected_results.push_back(r);
        mcount = (mcount + 1) & 64'h1FFFF;
    endtask

    task automatic judge_header(input logic [63:0] p);
        logic bad;
        logic [63:0] pk, up;
        pk = {32'b0, pk_acc};
        up = {32'b0, up_acc};
        bad = hbad || !nonblank;
        if (pk[31] || up[31]) bad = 1;
        if (pk > reg_max_size || up > reg_max_size) bad = 1;
        if (meth > M_IMPLODE) bad = 1;
        if (meth == M_STORED && pk != up) bad = 1;
        if (p + 1 + pk > reg_total) bad = 1;
        if (meth == M_IMPLODE && pk < 3) bad = 1;
        if (bad)
            close_chain();
        else if (meth == M_IMPLODE)
        begin
            ph = P_PRE; hdr_cnt = 0; pay_left = pk;
        end
        else
        begin
            pay_left = pk; ph = P_PAY;
        end
    endtask

    task automatic predict_archive_byte(input logic [7:0] b, input logic last);
        logic [63:0] p, ce;
        int k, n0;
        logic go, ok;
        rcav_pkg::result_t r;
        p = pos;
        n0 = expected_results.size();
        if (ph == P_HDR)
        begin
            k = hdr_cnt;
            go = 1;
            if (k == 0)
            begin
                rec_start = p;
                if (reg_total < rcav_pkg::MIN_TOTAL)
                begin
                    ph = P_FATAL; go = 0;
                end
                else if (p + rcav_pkg::HDR_LEN > reg_total)
                begin
                    close_chain(); go = 0;
                end
                else if (mcount >= reg_max_members)
                begin
                    ph = P_FATAL; go = 0;
                end
            end
            if (go)
            begin
                if (k == 0)
                begin
                    if (b != rcav_pkg::LEN_BYTE) hbad = 1;
                end
                else if (k <= 12)
                begin
                    if (b < rcav_pkg::BLANK_BYTE) hbad = 1;
                    if (b != rcav_pkg::BLANK_BYTE) nonblank = 1;
                end
                else if (k <= 16)
                    pk_acc |= {24'b0, b} << (8 * (k - 13));
                else if (k <= 20)
                    up_acc |= {24'b0, b} << (8 * (k - 17));
                else if (k <= 24)
                    stamp_acc |= {24'b0, b} << (8 * (k - 21));
                else if (k == 25)
                    meth = b;
                if (k >= 26)
                begin
                    if (b != rcav_pkg::MARKER_BYTE) hbad = 1;
                    judge_header(p);
                    if (ph == P_PAY)
                    begin
                        push_member();
                        if (pay_left == 0) open_record(p + 1);
                    end
                end
                else
                    hdr_cnt = k + 1;
            end
        end
        else if (ph == P_PRE)
        begin
            if (hdr_cnt == 0)
            begin
                if (b > 1) close_chain();
                else hdr_cnt = 1;
            end
            else if (b < 4 || b > 6)
                close_chain();
            else
            begin
                push_member();
                pay_left = (pay_left >= 2) ? pay_left - 2 : 0;
                ph = P_PAY;
                if (pay_left == 0) open_record(p + 1);
            end
        end
        else if (ph == P_PAY)
        begin
            if (pay_left > 0) pay_left--;
            if (pay_left == 0) open_record(p + 1);
        end
        if (p < POS_MAX) pos = p + 1;
        if (last)
        begin
            ce = (ph == P_DONE) ? chain_end : rec_start;
            ok = ph != P_FATAL && reg_total >= rcav_pkg::MIN_TOTAL && mcount >= 1 &&
                 p + 1 == reg_total &&
                 (ce == reg_total || ce + rcav_pkg::TRAILER_LEN == reg_total);
            r = '0;
            r.result_kind = KIND_VERDICT;
            r.archive_valid = ok;
            r.trailer_offset = ce[31:0];
            expected_results.push_back(r);
            clear_stream();
        end
        if (expected_results.size() > n0)
            expected_results[expected_results.size() - 1].last_result = 1'b1;
    endtask

    function automatic void check_field(input string name, input logic [63:0] e,
                                        input logic [63:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        rcav_pkg::result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("result_kind", e.result_kind, out_ch.result_kind);
                check_field("member_index", e.member_index, out_ch.member_index);
                check_field("header_offset", e.header_offset, out_ch.header_offset);
                check_field("data_offset", e.data_offset, out_ch.data_offset);
                check_field("packed_size", e.packed_size, out_ch.packed_size);
                check_field("unpacked_size", e.unpacked_size, out_ch.unpacked_size);
                check_field("dos_stamp", e.dos_stamp, out_ch.dos_stamp);
                check_field("pack_method", e.pack_method, out_ch.pack_method);
                check_field("archive_valid", e.archive_valid, out_ch.archive_valid);
                check_field("trailer_offset", e.trailer_offset,
                            out_ch.trailer_offset);
                check_field("last_result", e.last_result, out_ch.last_result);
                if (e.result_kind == KIND_MEMBER) members_seen++;
                else
                begin
                    verdicts_seen++;
                    if (e.archive_valid) valid_verdicts++;
                end
            end
        end
    end

    // Result receiver with random stalls and an optional long hold-off.
    initial
    begin
        int stall;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                out_ch.ready = 0;
                repeat (hold_req) @(negedge clk);
                hold_req = 0;
            end
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ch.ready = 0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_ch.valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1;
        in_ch.data_byte = b;
        in_ch.last_byte = last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_archive_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg.valid = 1;
        cfg.index = idx;
        cfg.data = val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            rcav_pkg::REG_TOTAL_SIZE: reg_total = {32'b0, val};
            rcav_pkg::REG_MAX_MEMBERS: reg_max_members = {47'b0, val[16:0]};
            rcav_pkg::REG_MAX_MEMBER_SIZE: reg_max_size = {33'b0, val[30:0]};
            default: ;
        endcase
        @(negedge clk);
        cfg.valid = 0;
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) arc_bytes.push_back(w[8 * i +: 8]);
    endtask

    task automatic add_member(input logic [7:0] m, input logic [31:0] psz,
                              input logic [31:0] usz, input fault_t f);
        int body;
        arc_bytes.push_back(f == F_LEN ? rcav_pkg::LEN_BYTE ^ 8'($urandom_range(1, 255))
                                       : rcav_pkg::LEN_BYTE);
        for (int i = 0; i < 12; i++)
        begin
            if (f == F_BLANK) arc_bytes.push_back(rcav_pkg::BLANK_BYTE);
            else if (f == F_CTRL && i == 5) arc_bytes.push_back(8'($urandom_range(0, 31)));
            else if (i == 0) arc_bytes.push_back(8'($urandom_range(33, 255)));
            else arc_bytes.push_back(8'($urandom_range(32, 255)));
        end
        add_word(psz);
        add_word(usz);
        add_word($urandom);
        arc_bytes.push_back(f == F_METH ? 8'($urandom_range(2, 255)) : m);
        arc_bytes.push_back(f == F_MARK ? rcav_pkg::MARKER_BYTE ^ 8'($urandom_range(1, 255))
                                        : rcav_pkg::MARKER_BYTE);
        body = (psz > 40) ? 40 : int'(psz);
        if (m == M_IMPLODE && f != F_METH && body >= 2)
        begin
            arc_bytes.push_back(f == F_PRE0 ? 8'($urandom_range(2, 255))
                                            : 8'($urandom_range(0, 1)));
            if (f == F_PRE1)
                arc_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                         : 8'($urandom_range(7, 255)));
            else
                arc_bytes.push_back(8'($urandom_range(4, 6)));
            body -= 2;
        end
        repeat (body) arc_bytes.push_back(8'($urandom));
    endtask

    task automatic add_good_member();
        logic [31:0] psz;
        if ($urandom_range(0, 2) == 0)
        begin
            psz = $urandom_range(3, 24);
            add_member(M_IMPLODE, psz, $urandom_range(0, 5000), F_NONE);
        end
        else
        begin
            psz = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 24);
            add_member(M_STORED, psz, psz, F_NONE);
        end
    endtask

    // Streams the built archive with total_size = length + adjust.
    task automatic run_archive(input int trail, input int adjust);
        repeat (trail) arc_bytes.push_back(8'($urandom));
        if (arc_bytes.size() == 0) arc_bytes.push_back(8'($urandom));
        write_reg(rcav_pkg::REG_TOTAL_SIZE, 32'(arc_bytes.size() + adjust));
        for (int i = 0; i < arc_bytes.size(); i++)
            send_byte(arc_bytes[i], i == arc_bytes.size() - 1);
        arc_bytes.delete();
        archives++;
        wait_drained();
    endtask

    task automatic test_well_formed();
        add_member(M_STORED, 0, 0, F_NONE);
        run_archive(rcav_pkg::TRAILER_LEN, 0);
        add_member(M_IMPLODE, 3, 32'h7FFF_FFFF, F_NONE);
        add_member(M_STORED, 4, 4, F_NONE);
        run_archive(0, 0);
        add_member(M_STORED, 2, 2, F_NONE);
        run_archive(3, 0);
    endtask

    task automatic test_header_faults();
        for (int f = F_LEN; f <= F_PRE1; f++)
        begin
            add_good_member();
            add_member(M_IMPLODE, 6, 9, fault_t'(f));
            run_archive(rcav_pkg::TRAILER_LEN, 0);
        end
        add_member(M_STORED, 5, 6, F_NONE);
        run_archive(0, 0);
        add_member(M_STORED, 32'h8000_0000, 32'h8000_0000, F_NONE);
        run_archive(0, 0);
        add_member(M_IMPLODE, 2, 2, F_NONE);
        run_archive(0, 0);
        add_member(M_STORED, 0, 0, F_NONE);
        run_archive(0, 0);
        add_member(M_STORED, 1, 1, F_NONE);
        add_member(M_STORED, 1, 1, F_NONE);
        run_archive(0, 9);
    endtask

    task automatic test_register_extremes();
        write_reg(rcav_pkg::REG_MAX_MEMBER_SIZE, 32'd0);
        add_member(M_STORED, 0, 0, F_NONE);
        add_member(M_STORED, 1, 1, F_NONE);
        run_archive(0, 0);
        write_reg(rcav_pkg::REG_MAX_MEMBER_SIZE, 32'h7FFF_FFFF);
        write_reg(rcav_pkg::REG_MAX_MEMBERS, 32'd1);
        add_member(M_STORED, 1, 1, F_NONE);
        add_member(M_STORED, 1, 1, F_NONE);
        run_archive(0, 0);
        write_reg(rcav_pkg::REG_MAX_MEMBERS, 32'd100000);
        add_member(M_STORED, 3, 3, F_NONE);
        run_archive(0, 32'hFFFF_FFFF - 30);
        repeat (4) arc_bytes.push_back(8'($urandom));
        run_archive(0, -4);
        write_reg(rcav_pkg::REG_MAX_MEMBER_SIZE, 32'h1000_0000);
    endtask

    task automatic test_random_archives();
        int pick;
        while (bytes_sent < 1700)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    write_reg(rcav_pkg::REG_MAX_MEMBERS, $urandom_range(1, 4));
                else if (pick == 1)
                    write_reg(rcav_pkg::REG_MAX_MEMBERS, 32'd100000);
                else if (pick == 2)
                    write_reg(rcav_pkg::REG_MAX_MEMBER_SIZE, $urandom_range(0, 30));
                else
                    write_reg(rcav_pkg::REG_MAX_MEMBER_SIZE, $urandom);
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
                repeat ($urandom_range(1, 40)) arc_bytes.push_back(8'($urandom));
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 5) == 0)
                        add_member($urandom_range(0, 1), $urandom_range(0, 12),
                                   $urandom_range(0, 12),
                                   fault_t'($urandom_range(F_NONE, F_PRE1)));
                    else
                        add_good_member();
                end
            end
            pick = $urandom_range(0, 9);
            run_archive(pick < 5 ? rcav_pkg::TRAILER_LEN
                                 : (pick < 8 ? 0 : $urandom_range(1, 7)),
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 6) - 3 : 0);
        end
        quiet = 0;
    endtask

    task automatic test_output_backpressure();
        @(negedge clk);
        hold_req = 300;
        repeat (20) add_member(M_STORED, 0, 0, F_NONE);
        run_archive(rcav_pkg::TRAILER_LEN, 0);
    endtask

    initial
    begin
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.data_byte = 0;
        in_ch.last_byte = 0;
        cfg.valid = 0;
        cfg.index = rcav_pkg::REG_TOTAL_SIZE;
        cfg.data = 0;
        reg_total = 0;
        reg_max_members = 100000;
        reg_max_size = 32'h1000_0000;
        clear_stream();
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_well_formed();
        test_header_faults();
        test_register_extremes();
        test_output_backpressure();
        test_random_archives();
        wait_drained();
        $display("tb: %0d archives, %0d bytes streamed", archives, bytes_sent);
        $display("tb: %0d descriptors and %0d verdicts checked, %0d valid",
                 members_seen, verdicts_seen, valid_verdicts);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
